// ----- rtl/tgl_pkg.sv -----
package tgl_pkg;

    localparam int GLYPH_WIDTH  = 6;
    localparam int GLYPH_HEIGHT = 13;
    localparam int COORD_BITS   = 12;

    localparam int CUR_BITS  = COORD_BITS + 1;
    localparam int CHAR_BITS = 7;
    localparam int COLOR_BITS = 24;
    localparam int CH_BITS   = 8;
    localparam int STYLE_BITS = 2;
    localparam int SRC_X_BITS = 8;
    localparam int SRC_Y_BITS = 6;

    localparam int MAX_COLS  = ((1 << COORD_BITS) - 1) / GLYPH_WIDTH;
    localparam int MAX_ROWS  = ((1 << COORD_BITS) - 1) / GLYPH_HEIGHT;
    localparam int COLS_BITS = $clog2(MAX_COLS + 1);
    localparam int ROWS_BITS = $clog2(MAX_ROWS + 1);
    localparam int LIMIT_BITS = $clog2(MAX_COLS * MAX_ROWS + 1);

    // reciprocal multiply for the division by glyph size
    localparam int COL_SHIFT = COORD_BITS + $clog2(GLYPH_WIDTH) + 1;
    localparam int ROW_SHIFT = COORD_BITS + $clog2(GLYPH_HEIGHT) + 1;
    localparam logic [COL_SHIFT:0] COL_RECIP =
        (COL_SHIFT + 1)'(((64'd1 << COL_SHIFT) + GLYPH_WIDTH - 1) / GLYPH_WIDTH);
    localparam logic [ROW_SHIFT:0] ROW_RECIP =
        (ROW_SHIFT + 1)'(((64'd1 << ROW_SHIFT) + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT);

    localparam logic [CUR_BITS-1:0] CUR_MAX = '1;

    localparam int ITALIC_OFFSET = 31;
    localparam logic [STYLE_BITS-1:0] STYLE_ITALIC = 2'd2;

    localparam logic [CHAR_BITS-1:0] CODE_NEWLINE = 7'h0A;
    localparam logic [CHAR_BITS-1:0] CODE_BLACK   = 7'h02;
    localparam logic [CHAR_BITS-1:0] CODE_RED     = 7'h03;
    localparam logic [CHAR_BITS-1:0] CODE_GREEN   = 7'h04;
    localparam logic [CHAR_BITS-1:0] CODE_BLUE    = 7'h05;

    localparam logic [COLOR_BITS-1:0] COLOR_BLACK = 24'h000000;
    localparam logic [COLOR_BITS-1:0] COLOR_RED   = 24'hFF0000;
    localparam logic [COLOR_BITS-1:0] COLOR_GREEN = 24'h00FF00;
    localparam logic [COLOR_BITS-1:0] COLOR_BLUE  = 24'h0000FF;
    localparam logic [COLOR_BITS-1:0] COLOR_WHITE = 24'hFFFFFF;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BOX_X         = 3'd0,
        REG_BOX_Y         = 3'd1,
        REG_BOX_WIDTH     = 3'd2,
        REG_BOX_HEIGHT    = 3'd3,
        REG_FONT_STYLE    = 3'd4,
        REG_DEFAULT_COLOR = 3'd5
    } cfg_reg_t;

    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 64;

endpackage

// ----- rtl/text_box_glyph_layout.sv -----
// Glyph layout for a text box: one character transaction in, at most one glyph-blit
// transaction out. The block accepts one character every cycle; a character passes
// an input register and the layout logic, and its blit command is then registered in
// the output register. The only stall comes from the output register: while a
// command waits on m_tready, a next character that would also produce a command
// holds in the input register. Registers are written through
// cfg_we/cfg_index/cfg_wdata; every write, and every character marked with tlast,
// returns the cursor to the box origin and the colour to default_color.
module text_box_glyph_layout (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [tgl_pkg::IN_DATA_BITS-1:0]         s_tdata,  // char_code, zero pad
    input  logic                                     s_tlast,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // src_x, src_y, dst_x, dst_y, red, green, blue
    output logic [tgl_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    output logic [tgl_pkg::STYLE_BITS-1:0]           m_tuser,  // style
    input  logic                                     cfg_we,
    input  logic [tgl_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [tgl_pkg::COLOR_BITS-1:0]           cfg_wdata
);

    localparam int CB  = tgl_pkg::COORD_BITS;
    localparam int CUB = tgl_pkg::CUR_BITS;

    function automatic logic [CUB-1:0] sat_add(input logic [CUB-1:0] a,
                                               input logic [CUB-1:0] b);
        logic [CUB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CUB] ? tgl_pkg::CUR_MAX : s[CUB-1:0];
    endfunction

    function automatic logic [tgl_pkg::COLOR_BITS-1:0] color_of(
        input logic [tgl_pkg::CHAR_BITS-1:0] code);
        logic [tgl_pkg::COLOR_BITS-1:0] c;
        unique case (code)
            tgl_pkg::CODE_BLACK: c = tgl_pkg::COLOR_BLACK;
            tgl_pkg::CODE_RED:   c = tgl_pkg::COLOR_RED;
            tgl_pkg::CODE_GREEN: c = tgl_pkg::COLOR_GREEN;
            tgl_pkg::CODE_BLUE:  c = tgl_pkg::COLOR_BLUE;
            default:             c = tgl_pkg::COLOR_WHITE;
        endcase
        return c;
    endfunction

    // configuration
    logic [CB-1:0] box_x_reg, box_x_next;
    logic [CB-1:0] box_y_reg, box_y_next;
    logic [CB-1:0] box_w_reg, box_w_next;
    logic [CB-1:0] box_h_reg, box_h_next;
    logic [tgl_pkg::STYLE_BITS-1:0] style_reg, style_next;
    logic [tgl_pkg::COLOR_BITS-1:0] dflt_color_reg, dflt_color_next;
    logic [tgl_pkg::COLS_BITS-1:0] cols_reg, cols_next;
    logic [tgl_pkg::ROWS_BITS-1:0] rows_reg, rows_next;

    logic [CB+tgl_pkg::COL_SHIFT:0] col_prod;
    logic [CB+tgl_pkg::ROW_SHIFT:0] row_prod;

    // string state
    logic [CUB-1:0] cursor_x_reg, cursor_x_next;
    logic [CUB-1:0] cursor_y_reg, cursor_y_next;
    logic [tgl_pkg::COLS_BITS-1:0] column_count_reg, column_count_next;
    logic [tgl_pkg::LIMIT_BITS-1:0] item_count_reg, item_count_next;
    logic [tgl_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic stopped_reg, stopped_next;

    // input stage
    logic in_valid_reg, in_valid_next;
    logic [tgl_pkg::CHAR_BITS-1:0] in_char_reg, in_char_next;
    logic in_last_reg, in_last_next;

    // output stage
    logic m_valid_reg, m_valid_next;
    logic [tgl_pkg::OUT_DATA_BITS-1:0] m_data_reg, m_data_next;
    logic [tgl_pkg::STYLE_BITS-1:0] m_user_reg, m_user_next;

    // layout datapath
    logic [tgl_pkg::COLS_BITS+tgl_pkg::ROWS_BITS-1:0] limit_prod;
    logic [tgl_pkg::LIMIT_BITS-1:0] limit;
    logic [CUB-1:0] bottom;
    logic active, at_bottom, is_ctrl, is_newline, produce, out_free, proc_fire;
    logic [tgl_pkg::CHAR_BITS-1:0] atlas_idx;
    logic [tgl_pkg::SRC_X_BITS-1:0] src_x;
    logic [tgl_pkg::SRC_Y_BITS-1:0] src_y;
    logic [tgl_pkg::COLS_BITS:0] col_inc;

    assign limit_prod = cols_reg * rows_reg;
    assign limit      = limit_prod[tgl_pkg::LIMIT_BITS-1:0];
    assign bottom     = {1'b0, box_y_reg} + {1'b0, box_h_reg};
    assign active     = !stopped_reg && (item_count_reg < limit);
    assign at_bottom  = cursor_y_reg >= bottom;
    assign is_ctrl    = (in_char_reg[tgl_pkg::CHAR_BITS-1:5] == '0);
    assign is_newline = (in_char_reg == tgl_pkg::CODE_NEWLINE);
    assign produce    = active && !at_bottom && !is_ctrl;
    assign out_free   = !m_valid_reg || m_tready;
    assign proc_fire  = in_valid_reg && (out_free || !produce);
    assign s_tready   = !in_valid_reg || proc_fire;

    assign atlas_idx = (style_reg == tgl_pkg::STYLE_ITALIC)
                     ? in_char_reg - tgl_pkg::CHAR_BITS'(tgl_pkg::ITALIC_OFFSET)
                     : in_char_reg;
    assign src_x = {atlas_idx[4:0], 3'b010};
    assign src_y = tgl_pkg::SRC_Y_BITS'({atlas_idx[6:5], 4'b0000})
                 - tgl_pkg::SRC_Y_BITS'(atlas_idx[6:5])
                 + tgl_pkg::SRC_Y_BITS'(2);
    assign col_inc = {1'b0, column_count_reg} + 1'b1;

    assign col_prod = (CB + tgl_pkg::COL_SHIFT + 1)'(cfg_wdata[CB-1:0])
                    * (CB + tgl_pkg::COL_SHIFT + 1)'(tgl_pkg::COL_RECIP);
    assign row_prod = (CB + tgl_pkg::ROW_SHIFT + 1)'(cfg_wdata[CB-1:0])
                    * (CB + tgl_pkg::ROW_SHIFT + 1)'(tgl_pkg::ROW_RECIP);

    always_comb begin
        box_x_next      = box_x_reg;
        box_y_next      = box_y_reg;
        box_w_next      = box_w_reg;
        box_h_next      = box_h_reg;
        style_next      = style_reg;
        dflt_color_next = dflt_color_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                tgl_pkg::REG_BOX_X:      box_x_next = cfg_wdata[CB-1:0];
                tgl_pkg::REG_BOX_Y:      box_y_next = cfg_wdata[CB-1:0];
                tgl_pkg::REG_BOX_WIDTH: begin
                    box_w_next = cfg_wdata[CB-1:0];
                    cols_next  = col_prod[tgl_pkg::COL_SHIFT +: tgl_pkg::COLS_BITS];
                end
                tgl_pkg::REG_BOX_HEIGHT: begin
                    box_h_next = cfg_wdata[CB-1:0];
                    rows_next  = row_prod[tgl_pkg::ROW_SHIFT +: tgl_pkg::ROWS_BITS];
                end
                tgl_pkg::REG_FONT_STYLE:    style_next = cfg_wdata[tgl_pkg::STYLE_BITS-1:0];
                tgl_pkg::REG_DEFAULT_COLOR: dflt_color_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        column_count_next = column_count_reg;
        item_count_next   = item_count_reg;
        color_next        = color_reg;
        stopped_next      = stopped_reg;

        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (proc_fire && active) begin
            item_count_next = item_count_reg + 1'b1;
            if (at_bottom) begin
                stopped_next = 1'b1;
            end else if (is_newline) begin
                cursor_x_next     = {1'b0, box_x_reg};
                cursor_y_next     = sat_add(cursor_y_reg, CUB'(tgl_pkg::GLYPH_HEIGHT));
                column_count_next = '0;
            end else if (is_ctrl) begin
                color_next = color_of(in_char_reg);
            end else begin
                m_valid_next = 1'b1;
                m_data_next  = {color_reg[7:0], color_reg[15:8], color_reg[23:16],
                                cursor_y_reg, cursor_x_reg, src_y, src_x};
                m_user_next  = style_reg;
                if (col_inc >= {1'b0, cols_reg}) begin
                    cursor_x_next     = {1'b0, box_x_reg};
                    cursor_y_next     = sat_add(cursor_y_reg,
                                                CUB'(tgl_pkg::GLYPH_HEIGHT));
                    column_count_next = '0;
                end else begin
                    cursor_x_next     = sat_add(cursor_x_reg,
                                                CUB'(tgl_pkg::GLYPH_WIDTH));
                    column_count_next = col_inc[tgl_pkg::COLS_BITS-1:0];
                end
            end
        end

        if (cfg_we || (proc_fire && in_last_reg)) begin
            cursor_x_next     = {1'b0, box_x_next};
            cursor_y_next     = {1'b0, box_y_next};
            column_count_next = '0;
            item_count_next   = '0;
            color_next        = dflt_color_next;
            stopped_next      = 1'b0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg && !proc_fire;
        in_char_next  = in_char_reg;
        in_last_next  = in_last_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_char_next  = s_tdata[tgl_pkg::CHAR_BITS-1:0];
            in_last_next  = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg        <= '0;
            box_y_reg        <= '0;
            box_w_reg        <= '0;
            box_h_reg        <= '0;
            style_reg        <= '0;
            dflt_color_reg   <= tgl_pkg::COLOR_WHITE;
            cols_reg         <= '0;
            rows_reg         <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            column_count_reg <= '0;
            item_count_reg   <= '0;
            color_reg        <= tgl_pkg::COLOR_WHITE;
            stopped_reg      <= 1'b0;
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            box_x_reg        <= box_x_next;
            box_y_reg        <= box_y_next;
            box_w_reg        <= box_w_next;
            box_h_reg        <= box_h_next;
            style_reg        <= style_next;
            dflt_color_reg   <= dflt_color_next;
            cols_reg         <= cols_next;
            rows_reg         <= rows_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            column_count_reg <= column_count_next;
            item_count_reg   <= item_count_next;
            color_reg        <= color_next;
            stopped_reg      <= stopped_next;
            in_valid_reg     <= in_valid_next;
            m_valid_reg      <= m_valid_next;
        end
        in_char_reg <= in_char_next;
        in_last_reg <= in_last_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/tgl_checker.sv -----
module tgl_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [tgl_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    input logic [tgl_pkg::STYLE_BITS-1:0]       m_tuser
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // atlas column is always on an 8 pixel grid plus two
    a_src_x_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] == 3'b010)
        else $error("bad atlas x");

    // atlas row is one of four rows of 15 pixels plus two
    a_src_y_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:8] == 6'd2 || m_tdata[13:8] == 6'd17 ||
                      m_tdata[13:8] == 6'd32 || m_tdata[13:8] == 6'd47))
        else $error("bad atlas y");

    // no result can show without an accepted transaction first
    a_no_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) && !$past(s_tready) == 1'b0 |=>
            !m_tvalid || $past(m_tvalid) || !$past(s_tready))
        else $error("result without input");

endmodule

bind text_box_glyph_layout tgl_checker u_tgl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
